// File: hdl/bpa_pkg.sv
// Package for the bitmap page allocator: map geometry, status codes, modes.
// No dependencies; used by bpa_map and bitmap_page_allocator_top.
`timescale 1ns / 1ps
package bpa_pkg;
  localparam int NUM_PAGES = 65536;
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_RUN = 1024;
  localparam int MAP_WORDS = (NUM_PAGES + 63) / 64;
  localparam int WORD_AW = $clog2(MAP_WORDS);
  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int ADDR_W = 28;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_OOM = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE = 2'd1,
    MODE_RESERVE = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_BASE = 2'd0,
    REG_LIMIT = 2'd1,
    REG_OFFSET = 2'd2
  } reg_index_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [WORD_AW-1:0]   waddr;
    logic [WORD_AW-1:0]   raddr;
    logic [63:0]          wdata;
  } map_req_t;
endpackage

// File: hdl/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator: config registers and sequencer.
// Depends on bpa_pkg and bpa_map.
//
//  channel | signals                         | handshake
//  request | start, mode, address, count     | accepted when start && !busy
//  result  | done, page_address, status      | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index,| written when cfg_valid && cfg_ready
//          | cfg_data                        |
//
// One request is handled at a time; busy is high from acceptance to the result.
// Allocate reads the map word by word from the base page to the bound, skipping
// a word that is all ones, starts at its bit 0 and lies below the bound, and
// otherwise scanning its 64 bits one per cycle.
// Free and reserve take a read and a write per touched word, bit by bit.
// After reset a clearing pass over all MAP_WORDS words runs with busy held high.
`timescale 1ns / 1ps
module bitmap_page_allocator_top
  import bpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [63:0]        address,
  input  logic [10:0]        count,
  output logic               done,
  output logic [ADDR_W-1:0]  page_address,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_WAIT, S_SCAN, S_WR, S_FIN
  } state_t;

  state_t       state;
  logic [16:0]  base_page;
  logic [16:0]  limit_page;
  logic [63:0]  offset;
  logic         op_alloc;
  logic         op_set;
  logic [10:0]  cnt;
  logic [10:0]  run;
  logic [16:0]  pos;
  logic [16:0]  pos_prev;
  logic [16:0]  bound;
  logic [PAGE_W-1:0] first;
  logic [63:0]  word;
  logic [1:0]   st;
  logic         marking;
  logic [63:0]  rdata;
  logic         init_done;
  map_req_t     req;

  // Free/reserve first page as a 17-bit value saturated past the map.
  logic [63:0]  phys;
  logic [51:0]  pg_full;
  logic [16:0]  pg_sat;
  assign phys = (mode == MODE_FREE && address >= offset) ? address - offset : address;
  assign pg_full = phys[63:PAGE_SHIFT];
  assign pg_sat = (pg_full >= 52'(NUM_PAGES)) ? 17'(NUM_PAGES) : pg_full[16:0];

  assign cfg_ready = (state == S_IDLE) && init_done;
  assign busy = (state != S_IDLE) || !init_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page <= 17'd1;
      limit_page <= '0;
      offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE: base_page <= cfg_data[16:0];
        REG_LIMIT: limit_page <= cfg_data[16:0];
        REG_OFFSET: offset <= cfg_data;
        default: ;
      endcase
    end
  end

  logic bit_used;
  assign bit_used = word[pos[5:0]];

  // The word is flushed after pos has moved past the last bit written.
  assign pos_prev = pos - 17'd1;

  always_comb begin
    req = '0;
    req.raddr = pos[PAGE_W-1:6];
    req.waddr = pos_prev[PAGE_W-1:6];
    req.wdata = word;
    req.rd = (state == S_RD);
    req.wr = (state == S_WR);
  end

  bpa_map u_map (
    .clk(clk), .rst(rst), .req(req), .rdata(rdata), .init_done(init_done)
  );

  // First page of the run that ends at pos, or pos itself for a zero count.
  assign first = (cnt == 11'd0) ? pos[PAGE_W-1:0] : PAGE_W'(pos - 17'(cnt) + 17'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && init_done) begin
            cnt <= count;
            run <= '0;
            st <= ST_DONE;
            page_address <= '0;
            op_alloc <= (mode == MODE_ALLOC);
            op_set <= (mode != MODE_FREE);
            marking <= 1'b0;
            if (mode == MODE_UNUSED || count > 11'(MAX_RUN) ||
                (mode == MODE_FREE && (address == 64'd0 || count == 11'd0))) begin
              st <= ST_IGNORED;
              state <= S_FIN;
            end else if (mode == MODE_ALLOC) begin
              bound <= (limit_page < 17'(NUM_PAGES)) ? limit_page : 17'(NUM_PAGES);
              pos <= base_page;
              state <= S_RD;
            end else if (count == 11'd0) begin
              state <= S_FIN;
            end else begin
              pos <= pg_sat;
              // run counts how many pages remain to write
              run <= count;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (op_alloc && !marking && pos >= bound) begin
            st <= ST_OOM;
            state <= S_FIN;
          end else if (!op_alloc || marking) begin
            if (pos >= 17'(NUM_PAGES)) begin
              st <= ST_IGNORED;
              state <= S_FIN;
            end else begin
              state <= S_WAIT;
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          word <= rdata;
          if (op_alloc && !marking && rdata == '1 && pos[5:0] == 6'd0 &&
              pos + 17'd64 <= bound) begin
            run <= '0;
            pos <= pos + 17'd64;
            state <= S_RD;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (op_alloc && !marking) begin
            if (pos >= bound) begin
              st <= ST_OOM;
              state <= S_FIN;
            end else if (bit_used) begin
              run <= '0;
              pos <= pos + 1'b1;
              if (pos[5:0] == 6'd63) state <= S_RD;
            end else if (cnt == 11'd0 || run + 11'd1 >= cnt) begin
              page_address <= {first, {PAGE_SHIFT{1'b0}}};
              if (cnt == 11'd0) begin
                state <= S_FIN;
              end else begin
                marking <= 1'b1;
                run <= cnt;
                pos <= pos - 17'(cnt) + 17'd1;
                state <= S_RD;
              end
            end else begin
              run <= run + 1'b1;
              pos <= pos + 1'b1;
              if (pos[5:0] == 6'd63) state <= S_RD;
            end
          end else begin
            // Write one bit of the run; flush the word at its end or run end.
            word[pos[5:0]] <= op_set;
            run <= run - 1'b1;
            pos <= pos + 1'b1;
            if (run == 11'd1 || pos[5:0] == 6'd63) state <= S_WR;
          end
        end
        S_WR: begin
          // pos already advanced; write address uses the previous word
          state <= (run == 11'd0) ? S_FIN : S_RD;
        end
        S_FIN: begin
          done <= 1'b1;
          status <= st;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready) else $error("config taken while busy");
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> done) else $error("finish without result");
`endif
endmodule

// File: hdl/bpa_map.sv
// Used-page bitmap memory: one write port, one registered read port.
// Depends on bpa_pkg. A clearing pass after reset fills every word with ones.
`timescale 1ns / 1ps
module bpa_map
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  map_req_t    req,
  output logic [63:0] rdata,
  output logic        init_done
);
  logic [63:0] mem [MAP_WORDS];
  logic [WORD_AW:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (!fill[WORD_AW]) begin
      fill <= fill + 1'b1;
    end
  end

  assign init_done = fill[WORD_AW];

  always_ff @(posedge clk) begin
    if (!fill[WORD_AW]) begin
      mem[fill[WORD_AW-1:0]] <= '1;
    end else if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// File: dv/bitmap_page_allocator_top_tb.sv
// Self-checking testbench for bitmap_page_allocator_top: a request driver fed from a queue,
// a result monitor, and a page-map predictor checked field by field on each done strobe.
// Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module bitmap_page_allocator_top_tb;
  import bpa_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [63:0] address;
    logic [10:0] count;
  } page_req_t;

  typedef struct {
    logic [ADDR_W-1:0] page_address;
    logic [1:0]        status;
  } page_resp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        mode = MODE_ALLOC;
  logic [63:0]       address = '0;
  logic [10:0]       count = '0;
  logic              done;
  logic [ADDR_W-1:0] page_address;
  logic [1:0]        status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = REG_BASE;
  logic [63:0]       cfg_data = '0;

  page_req_t   pending_reqs[$];
  page_resp_t  expected_resps[$];
  bit          used_pages[NUM_PAGES];
  longint unsigned base_page = 1;
  longint unsigned limit_page = 0;
  longint unsigned map_offset = 0;
  int          idle_pct = 0;
  int          errors = 0;

  bitmap_page_allocator_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .address(address),
    .count(count), .done(done), .page_address(page_address), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Sets or clears a run of pages; returns 1 if any page lies beyond the map.
  function automatic bit mark_run(longint unsigned first, longint unsigned n, bit val);
    bit outside;
    outside = 0;
    for (longint unsigned k = 0; k < n; k++) begin
      if (first + k >= NUM_PAGES) outside = 1;
      else used_pages[first + k] = val;
    end
    return outside;
  endfunction

  function automatic page_resp_t predict_request(page_req_t r);
    page_resp_t      res;
    longint unsigned bound, run, first, phys;
    bit              found;
    res.page_address = '0;
    res.status = ST_DONE;
    run = 0;
    first = 0;
    found = 0;
    if (r.mode == MODE_UNUSED || r.count > MAX_RUN) begin
      res.status = ST_IGNORED;
    end else if (r.mode == MODE_ALLOC) begin
      bound = (limit_page < NUM_PAGES) ? limit_page : NUM_PAGES;
      for (longint unsigned i = base_page; i < bound && !found; i++) begin
        if (used_pages[i]) begin
          run = 0;
        end else begin
          run++;
          if (r.count == 0) begin
            first = i;
            found = 1;
          end else if (run >= r.count) begin
            first = i + 1 - r.count;
            found = 1;
          end
        end
      end
      if (found) begin
        if (r.count != 0) void'(mark_run(first, r.count, 1));
        res.page_address = ADDR_W'(first * PAGE_BYTES);
      end else begin
        res.status = ST_OOM;
      end
    end else if (r.mode == MODE_FREE) begin
      if (r.address == 0 || r.count == 0) begin
        res.status = ST_IGNORED;
      end else begin
        phys = (r.address >= map_offset) ? r.address - map_offset : r.address;
        if (mark_run(phys / PAGE_BYTES, r.count, 0)) res.status = ST_IGNORED;
      end
    end else begin
      if (mark_run(r.address / PAGE_BYTES, r.count, 1)) res.status = ST_IGNORED;
    end
    return res;
  endfunction

  // Request driver: predicts each accepted transaction, then loads the next one or idles.
  always @(posedge clk) begin
    page_req_t nxt;
    if (!rst && start && !busy)
      expected_resps.push_back(predict_request('{mode, address, count}));
    if (!rst && (!start || !busy)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nxt = pending_reqs.pop_front();
        mode <= nxt.mode;
        address <= nxt.address;
        count <= nxt.count;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    page_resp_t exp_r;
    if (!rst && done) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result page_address=%h status=%0d", $time, page_address,
                 status);
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (page_address !== exp_r.page_address) begin
          $display("%0t: page_address mismatch expected %h actual %h", $time,
                   exp_r.page_address, page_address);
          errors++;
        end
        if (status !== exp_r.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time, exp_r.status,
                   status);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BASE:  base_page = val[16:0];
      REG_LIMIT: limit_page = val[16:0];
      default:   map_offset = val;
    endcase
  endtask

  task automatic configure(logic [63:0] b, logic [63:0] l, logic [63:0] o);
    write_reg(REG_BASE, b);
    write_reg(REG_LIMIT, l);
    write_reg(REG_OFFSET, o);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || start || busy)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_req(logic [1:0] m, logic [63:0] a, logic [10:0] c);
    pending_reqs.push_back('{m, a, c});
  endtask

  // Mostly well-formed traffic inside a page window, plus some fully random noise.
  task automatic push_random(int n, int wlo, int whi);
    int              kind, pg, cnt;
    longint unsigned phys;
    repeat (n) begin
      kind = $urandom_range(99);
      pg = $urandom_range(whi, wlo);
      phys = longint'(pg) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(MAX_RUN) : $urandom_range(24);
      if (kind < 40)
        push_req(MODE_ALLOC, {$urandom(), $urandom()}, 11'(cnt));
      else if (kind < 70)
        push_req(MODE_FREE, ($urandom_range(3) == 0) ? phys : phys + map_offset, 11'(cnt));
      else if (kind < 85)
        push_req(MODE_RESERVE, phys, 11'($urandom_range(12)));
      else
        push_req(2'($urandom_range(3)), {$urandom(), $urandom()}, 11'($urandom_range(2047)));
    end
  endtask

  initial begin
    // The map comes out of reset with every page used.
    foreach (used_pages[i]) used_pages[i] = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    configure(1, 256, 0);
    push_req(MODE_ALLOC, 0, 0);              // everything starts used
    push_req(MODE_ALLOC, 0, 5);
    push_req(MODE_FREE, 0, 4);               // address zero is ignored
    push_req(MODE_FREE, 64'h1000, 0);        // zero count is ignored
    push_req(MODE_FREE, 64'h1000, 100);
    push_req(MODE_ALLOC, 0, 0);              // peek at first free page
    push_req(MODE_ALLOC, 0, 3);
    push_req(MODE_ALLOC, 0, 1024);
    push_req(MODE_ALLOC, 0, 1025);
    push_req(MODE_FREE, 64'h2000, 11'h7FF);
    push_req(MODE_RESERVE, 64'h2000, 1025);
    push_req(MODE_UNUSED, '1, 1);
    push_req(MODE_RESERVE, 64'h3000, 0);
    push_req(MODE_RESERVE, 64'h5000, 2);
    push_req(MODE_FREE, 64'h0FFF_A000, 10);  // run crosses the top of the map
    push_req(MODE_RESERVE, 64'h0FFF_A000, 10);
    push_req(MODE_FREE, '1, 1);
    push_req(MODE_RESERVE, '1, 1024);
    push_req(MODE_FREE, 64'h0001_0000, 1024);
    push_req(MODE_ALLOC, 0, 1024);
    push_req(MODE_ALLOC, 0, 0);
    drain();

    configure(1, 512, 0);
    idle_pct = 0;
    push_random(200, 0, 600);
    drain();
    configure(64, 1024, 64'hFFFF_8000_0000_0000);
    idle_pct = 77;
    push_random(200, 0, 1100);
    drain();
    configure(0, 300, {$urandom(), $urandom()});
    idle_pct = 9;
    push_random(200, 0, 400);
    drain();
    configure(17'h10000, 17'h10000, 0);      // empty search window
    idle_pct = 0;
    push_random(30, 0, 300);
    drain();
    configure(0, 17'h1FFFF, '1);
    idle_pct = 77;
    push_random(40, 0, 2047);
    drain();
    configure(65000, 65536, 0);
    idle_pct = 9;
    push_random(200, 64900, 65535);
    drain();
    configure(3, 200, 64'h0000_7000_0000_0000);
    idle_pct = 0;
    push_random(200, 0, 260);
    drain();

    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // A timeout that ends the simulation as failed if the tests hang.
  initial begin
    repeat (40) #100_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

// File: bitmap_page_allocator_top.f
hdl/bpa_pkg.sv
hdl/bpa_map.sv
hdl/bitmap_page_allocator_top.sv
dv/bitmap_page_allocator_top_tb.sv
